// ----- rtl/poly_coeff_store_integrator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial coefficient store
// Implication checks, same cycle and next cycle, on clk with rst_n.
// ----------------------------------------------------------------------------
`ifndef POLY_COEFF_STORE_INTEGRATOR_ASSERT_SVH
`define POLY_COEFF_STORE_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PCSI_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcsi: same-cycle check failed");
`define PCSI_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcsi: next-cycle check failed");
`else
`define PCSI_IMPLY(label, ante, cons)
`define PCSI_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/pcsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsi_pkg
// Shared constants, types and saturation for the coefficient store.
// ----------------------------------------------------------------------------
package pcsi_pkg;

    localparam int NUM_COEFFS = 16;
    localparam int IDX_W      = $clog2(NUM_COEFFS);
    localparam int DIVR_W     = $clog2(NUM_COEFFS + 1);

    localparam int CMD_W  = 3;
    localparam int EXP_W  = 6;
    localparam int DEG_W  = 6;
    localparam int Q_W    = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * Q_W;
    localparam int RND_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = RND_W + 1;

    localparam int IN_W  = 104;
    localparam int OUT_W = 40;

    localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INTEG = 3'd4;

    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        q_t   value;
        logic ovf;
    } sat_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        q_t               coef;
        q_t               intg;
    } store_wr_t;

    // clamp to Q16.16, flag on clamp
    function automatic sat_t sat_q(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (v[SUM_W-1:Q_W-1] == '0 || v[SUM_W-1:Q_W-1] == '1)
        begin
            r.value = v[Q_W-1:0];
            r.ovf   = 1'b0;
        end
        else
        begin
            r.ovf   = 1'b1;
            r.value = v[SUM_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- rtl/poly_coeff_store_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_coeff_store_integrator
// Q16.16 polynomial store with set, add, clear, evaluate and definite
// integral, sequenced over one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel; command in s_tuser, operands in s_tdata.
// Every request returns exactly one result on the m_ channel.
// s_tready is high only while the sequencer is idle; once a request is taken,
// the block is busy until its result is registered.
// Evaluate: Horner over the table on the shared multiplier.
// Integral: both bounds run interleaved on the same multiplier, then one
// more Horner step and a final subtract.
// Set and add: the scaled coefficient c/(i+1) is formed by the bit-serial
// divider.
// The result register holds its result until m_tready; a new request may be
// taken meanwhile, and its result waits in the final state for the register.
// Reset empties the table (all coefficients read as zero) and the output.
// ----------------------------------------------------------------------------
`include "poly_coeff_store_integrator_assert.svh"

module poly_coeff_store_integrator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // exponent[5:0], value[37:6], point_a[69:38], point_b[101:70], zero pad
    input  logic [pcsi_pkg::IN_W-1:0]     s_tdata,
    // command[2:0]
    input  logic [pcsi_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value[31:0], overflow[32], status[33], degree[39:34]
    output logic [pcsi_pkg::OUT_W-1:0]    m_tdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WR    = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_LOAD  = 4'd4;
    localparam logic [3:0] S_RUN   = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_DIFF  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]                   state_reg, state_next;
    logic [pcsi_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [pcsi_pkg::EXP_W-1:0]   exp_reg, exp_next;
    pcsi_pkg::q_t                 val_reg, val_next;
    pcsi_pkg::q_t                 xa_reg, xa_next;
    pcsi_pkg::q_t                 xb_reg, xb_next;
    pcsi_pkg::q_t                 acc0_reg, acc0_next;
    pcsi_pkg::q_t                 acc1_reg, acc1_next;
    pcsi_pkg::q_t                 add_reg, add_next;
    pcsi_pkg::q_t                 newc_reg, newc_next;
    pcsi_pkg::q_t                 res_reg, res_next;
    logic [pcsi_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         fin_reg, fin_next;
    logic                         lane_reg, lane_next;
    logic                         pv_reg, pv_next;
    logic                         plane_reg, plane_next;
    logic                         ovf_reg, ovf_next;
    logic                         status_reg, status_next;
    logic                         m_valid_reg, m_valid_next;
    logic [pcsi_pkg::OUT_W-1:0]   out_reg, out_next;

    logic                         accept;
    logic                         integ;
    logic                         exp_bad;
    logic [pcsi_pkg::EXP_W-1:0]   in_exp;
    pcsi_pkg::q_t                 in_val;
    pcsi_pkg::q_t                 in_pa;
    pcsi_pkg::q_t                 in_pb;

    pcsi_pkg::store_wr_t          store_wr;
    logic                         store_clear;
    logic [pcsi_pkg::IDX_W-1:0]   rd_idx;
    pcsi_pkg::q_t                 rd_coef;
    pcsi_pkg::q_t                 rd_intg;
    pcsi_pkg::q_t                 rd_pick;
    logic [pcsi_pkg::DEG_W-1:0]   degree;

    logic                         mul_en;
    pcsi_pkg::q_t                 mac_a;
    pcsi_pkg::q_t                 mac_b;
    pcsi_pkg::q_t                 addend;
    pcsi_pkg::sat_t               mac_res;

    logic                         div_start;
    logic                         div_done;
    pcsi_pkg::q_t                 div_quo;

    pcsi_pkg::sat_t               wr_sum;
    pcsi_pkg::q_t                 wr_new;
    pcsi_pkg::sat_t               diff;

    assign in_exp = s_tdata[5:0];
    assign in_val = s_tdata[37:6];
    assign in_pa  = s_tdata[69:38];
    assign in_pb  = s_tdata[101:70];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign integ    = (cmd_reg == pcsi_pkg::CMD_INTEG);
    assign exp_bad  = ({1'b0, in_exp} >= (pcsi_pkg::EXP_W + 1)'(pcsi_pkg::NUM_COEFFS));

    assign rd_idx  = (state_reg == S_WR) ? exp_reg[pcsi_pkg::IDX_W-1:0] : idx_reg;
    assign rd_pick = integ ? rd_intg : rd_coef;

    // lane 0 takes the live table read, lane 1 reuses it in the next cycle
    assign addend = plane_reg ? add_reg : (fin_reg ? '0 : rd_pick);
    assign mul_en = (state_reg == S_RUN);
    assign mac_a  = lane_reg ? acc1_reg : acc0_reg;
    assign mac_b  = lane_reg ? xb_reg : xa_reg;

    assign wr_sum = pcsi_pkg::sat_q(pcsi_pkg::SUM_W'(rd_coef) + pcsi_pkg::SUM_W'(val_reg));
    assign wr_new = (cmd_reg == pcsi_pkg::CMD_SET) ? val_reg : wr_sum.value;
    assign diff   = pcsi_pkg::sat_q(pcsi_pkg::SUM_W'(acc1_reg) - pcsi_pkg::SUM_W'(acc0_reg));

    assign div_start = (state_reg == S_WR);

    pcsi_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (store_wr),
        .clear   (store_clear),
        .rd_idx  (rd_idx),
        .rd_coef (rd_coef),
        .rd_intg (rd_intg),
        .degree  (degree)
    );

    pcsi_mac u_mac (
        .clk    (clk),
        .mul_en (mul_en),
        .a      (mac_a),
        .b      (mac_b),
        .addend (addend),
        .res    (mac_res)
    );

    pcsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wr_new),
        .divisor  (pcsi_pkg::DIVR_W'(exp_reg[pcsi_pkg::IDX_W-1:0]) + pcsi_pkg::DIVR_W'(1)),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        exp_next     = exp_reg;
        val_next     = val_reg;
        xa_next      = xa_reg;
        xb_next      = xb_reg;
        acc0_next    = acc0_reg;
        acc1_next    = acc1_reg;
        add_next     = add_reg;
        newc_next    = newc_reg;
        res_next     = res_reg;
        idx_next     = idx_reg;
        fin_next     = fin_reg;
        lane_next    = lane_reg;
        pv_next      = pv_reg;
        plane_next   = plane_reg;
        ovf_next     = ovf_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        out_next     = out_reg;
        store_wr     = '0;
        store_clear  = 1'b0;

        // Horner update of the lane whose product is in the multiplier register
        if ((state_reg == S_RUN || state_reg == S_DRAIN) && pv_reg)
        begin
            if (plane_reg)
            begin
                acc1_next = mac_res.value;
            end
            else
            begin
                acc0_next = mac_res.value;
                add_next  = addend;
            end
            if (integ || !plane_reg)
            begin
                ovf_next = ovf_reg | mac_res.ovf;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_tuser;
                    exp_next    = in_exp;
                    val_next    = in_val;
                    xa_next     = in_pa;
                    xb_next     = in_pb;
                    ovf_next    = 1'b0;
                    status_next = 1'b0;
                    res_next    = '0;
                    idx_next    = pcsi_pkg::IDX_W'(pcsi_pkg::NUM_COEFFS - 1);
                    priority if (s_tuser == pcsi_pkg::CMD_SET || s_tuser == pcsi_pkg::CMD_ADD)
                    begin
                        if (exp_bad)
                        begin
                            status_next = 1'b1;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_WR;
                        end
                    end
                    else if (s_tuser == pcsi_pkg::CMD_CLEAR)
                    begin
                        state_next = S_CLR;
                    end
                    else if (s_tuser == pcsi_pkg::CMD_EVAL || s_tuser == pcsi_pkg::CMD_INTEG)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_WR:
            begin
                newc_next = wr_new;
                if (cmd_reg == pcsi_pkg::CMD_ADD)
                begin
                    ovf_next = wr_sum.ovf;
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    store_wr.en   = 1'b1;
                    store_wr.idx  = exp_reg[pcsi_pkg::IDX_W-1:0];
                    store_wr.coef = newc_reg;
                    store_wr.intg = div_quo;
                    state_next    = S_FIN;
                end
            end
            S_CLR:
            begin
                store_clear = 1'b1;
                state_next  = S_FIN;
            end
            S_LOAD:
            begin
                acc0_next  = rd_pick;
                acc1_next  = rd_pick;
                idx_next   = pcsi_pkg::IDX_W'(pcsi_pkg::NUM_COEFFS - 2);
                fin_next   = 1'b0;
                lane_next  = 1'b0;
                pv_next    = 1'b0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                pv_next    = 1'b1;
                plane_next = lane_reg;
                lane_next  = ~lane_reg;
                if (lane_reg)
                begin
                    if (integ ? fin_reg : (idx_reg == '0))
                    begin
                        state_next = S_DRAIN;
                    end
                    else if (idx_reg == '0)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                pv_next    = 1'b0;
                res_next   = acc0_reg;
                state_next = integ ? S_DIFF : S_FIN;
            end
            S_DIFF:
            begin
                res_next   = diff.value;
                ovf_next   = ovf_reg | diff.ovf;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    out_next     = {degree, status_reg, ovf_reg, res_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            fin_reg     <= 1'b0;
            lane_reg    <= 1'b0;
            pv_reg      <= 1'b0;
            plane_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            fin_reg     <= fin_next;
            lane_reg    <= lane_next;
            pv_reg      <= pv_next;
            plane_reg   <= plane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        exp_reg    <= exp_next;
        val_reg    <= val_next;
        xa_reg     <= xa_next;
        xb_reg     <= xb_next;
        acc0_reg   <= acc0_next;
        acc1_reg   <= acc1_next;
        add_reg    <= add_next;
        newc_reg   <= newc_next;
        res_reg    <= res_next;
        ovf_reg    <= ovf_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    `PCSI_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)
    `PCSI_IMPLY(a_div_done_in_div, div_done, state_reg == S_DIV)
    `PCSI_NEXT(a_fin_waits, state_reg == S_FIN && m_tvalid && !m_tready, state_reg == S_FIN)
    `PCSI_IMPLY(a_drain_lane_one, state_reg == S_DRAIN, pv_reg && plane_reg)

endmodule

// ----- rtl/pcsi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsi_div
// Bit-serial restoring divider: signed Q16.16 value by a small divisor,
// truncated toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pcsi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  pcsi_pkg::q_t                dividend,
    input  logic [pcsi_pkg::DIVR_W-1:0] divisor,
    output logic                        done,
    output pcsi_pkg::q_t                quotient
);

    localparam int CNT_W = $clog2(pcsi_pkg::Q_W);

    logic [pcsi_pkg::Q_W-1:0]  quo_reg;
    logic [pcsi_pkg::DIVR_W-1:0] rem_reg;
    logic [pcsi_pkg::DIVR_W-1:0] dvs_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      run_reg;
    logic                      done_reg;

    logic [pcsi_pkg::DIVR_W:0] trial;
    logic                      ge;

    assign trial = {rem_reg, quo_reg[pcsi_pkg::Q_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(pcsi_pkg::Q_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[pcsi_pkg::Q_W-1];
            quo_reg <= dividend[pcsi_pkg::Q_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? pcsi_pkg::DIVR_W'(trial - {1'b0, dvs_reg})
                          : trial[pcsi_pkg::DIVR_W-1:0];
            quo_reg <= {quo_reg[pcsi_pkg::Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ----- rtl/pcsi_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsi_mac
// Shared Q16.16 multiplier with registered product, then round half up,
// add and saturate.
// ----------------------------------------------------------------------------
module pcsi_mac (
    input  logic                clk,
    input  logic                mul_en,
    input  pcsi_pkg::q_t        a,
    input  pcsi_pkg::q_t        b,
    input  pcsi_pkg::q_t        addend,
    output pcsi_pkg::sat_t      res
);

    logic signed [pcsi_pkg::PROD_W-1:0] prod_reg;
    logic signed [pcsi_pkg::PROD_W-1:0] rnd_full;
    logic signed [pcsi_pkg::RND_W-1:0]  rnd;
    logic signed [pcsi_pkg::SUM_W-1:0]  sum;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= pcsi_pkg::PROD_W'(a) * pcsi_pkg::PROD_W'(b);
        end
    end

    assign rnd_full = (prod_reg + pcsi_pkg::PROD_W'(1 << (pcsi_pkg::FRAC_W - 1)))
                      >>> pcsi_pkg::FRAC_W;
    assign rnd      = $signed(rnd_full[pcsi_pkg::RND_W-1:0]);
    assign sum      = pcsi_pkg::SUM_W'(rnd) + pcsi_pkg::SUM_W'(addend);
    assign res      = pcsi_pkg::sat_q(sum);

endmodule

// ----- rtl/pcsi_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsi_store
// Coefficient and scaled-coefficient registers with nonzero bits, one
// read port and the degree encoder.
// ----------------------------------------------------------------------------
module pcsi_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcsi_pkg::store_wr_t          wr,
    input  logic                         clear,
    input  logic [pcsi_pkg::IDX_W-1:0]   rd_idx,
    output pcsi_pkg::q_t                 rd_coef,
    output pcsi_pkg::q_t                 rd_intg,
    output logic [pcsi_pkg::DEG_W-1:0]   degree
);

    pcsi_pkg::q_t                    coef_mem [pcsi_pkg::NUM_COEFFS];
    pcsi_pkg::q_t                    intg_mem [pcsi_pkg::NUM_COEFFS];
    logic [pcsi_pkg::NUM_COEFFS-1:0] nz_reg;
    logic [pcsi_pkg::NUM_COEFFS-1:0] nz_next;
    logic [pcsi_pkg::IDX_W-1:0]      deg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            coef_mem[wr.idx] <= wr.coef;
            intg_mem[wr.idx] <= wr.intg;
        end
    end

    always_comb
    begin
        nz_next = nz_reg;
        if (clear)
        begin
            nz_next = '0;
        end
        else if (wr.en)
        begin
            nz_next[wr.idx] = (wr.coef != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg <= '0;
        end
        else
        begin
            nz_reg <= nz_next;
        end
    end

    // entry not marked nonzero reads as zero
    assign rd_coef = nz_reg[rd_idx] ? coef_mem[rd_idx] : '0;
    assign rd_intg = nz_reg[rd_idx] ? intg_mem[rd_idx] : '0;

    always_comb
    begin
        deg = '0;
        for (int i = 1; i < pcsi_pkg::NUM_COEFFS; i++)
        begin
            if (nz_reg[i])
            begin
                deg = pcsi_pkg::IDX_W'(i);
            end
        end
    end

    assign degree = pcsi_pkg::DEG_W'(deg);

endmodule

// ----- tb/poly_coeff_store_integrator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_coeff_store_integrator_tb
// Self-checking bench for the Q16.16 polynomial store. A scoreboard keeps its
// own coefficient table and predicts every result. Directed requests cover
// the extremes, then random requests follow, with random gaps and stalls on
// both sides, a long output hold-off, a full drain and a burst stretch.
// ----------------------------------------------------------------------------
module poly_coeff_store_integrator_tb;

    import pcsi_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_COUNT   = 500;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_INTEG + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;
    localparam q_t Q_ONE = 32'sh0001_0000;

    typedef struct {
        q_t               value;
        bit               ovf;
        bit               status;
        logic [DEG_W-1:0] degree;
    } poly_result_t;

    class poly_scoreboard;
        q_t           coeffs [NUM_COEFFS];
        poly_result_t expected_q [$];
        int           mismatches;

        function new();
            clear_table();
            mismatches = 0;
        endfunction

        function void clear_table();
            int i;
            for (i = 0; i < NUM_COEFFS; i++)
                coeffs[i] = '0;
        endfunction

        function q_t sat_word(longint v, inout bit ovf);
            if (v > longint'(Q_MAX))
            begin
                ovf = 1'b1;
                return Q_MAX;
            end
            if (v < longint'(Q_MIN))
            begin
                ovf = 1'b1;
                return Q_MIN;
            end
            return q_t'(v);
        endfunction

        // round half up, floor shift
        function longint q_mul(q_t a, q_t b);
            longint p;
            p = longint'(a) * longint'(b);
            return (p + 64'sd32768) >>> FRAC_W;
        endfunction

        function q_t horner(q_t x, bit integ, inout bit ovf);
            q_t     acc;
            longint c;
            int     i;
            acc = '0;
            for (i = NUM_COEFFS - 1; i >= 0; i--)
            begin
                c = longint'(coeffs[i]);
                if (integ)
                    c = c / longint'(i + 1);
                if (i == NUM_COEFFS - 1)
                    acc = q_t'(c);
                else
                    acc = sat_word(q_mul(acc, x) + c, ovf);
            end
            if (integ)
                acc = sat_word(q_mul(acc, x), ovf);
            return acc;
        endfunction

        function logic [DEG_W-1:0] degree_now();
            int i;
            for (i = NUM_COEFFS - 1; i > 0; i--)
                if (coeffs[i] != 0)
                    return DEG_W'(i);
            return '0;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [EXP_W-1:0] expo,
                                   q_t val, q_t pa, q_t pb);
            poly_result_t r;
            q_t           fa;
            q_t           fb;
            r.value  = '0;
            r.ovf    = 1'b0;
            r.status = 1'b0;
            case (cmd)
                CMD_SET, CMD_ADD:
                begin
                    if (expo >= NUM_COEFFS)
                        r.status = 1'b1;
                    else if (cmd == CMD_SET)
                        coeffs[expo] = val;
                    else
                        coeffs[expo] = sat_word(longint'(coeffs[expo]) + longint'(val),
                                                r.ovf);
                end
                CMD_CLEAR:
                    clear_table();
                CMD_EVAL:
                    r.value = horner(pa, 1'b0, r.ovf);
                CMD_INTEG:
                begin
                    fa      = horner(pa, 1'b1, r.ovf);
                    fb      = horner(pb, 1'b1, r.ovf);
                    r.value = sat_word(longint'(fb) - longint'(fa), r.ovf);
                end
                default:
                    ;
            endcase
            r.degree = degree_now();
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            poly_result_t e;
            q_t           act_value;
            logic         act_ovf;
            logic         act_status;
            logic [DEG_W-1:0] act_degree;
            act_value  = data[31:0];
            act_ovf    = data[32];
            act_status = data[33];
            act_degree = data[39:34];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result value=%h ovf=%b status=%b degree=%0d",
                             $realtime, act_value, act_ovf, act_status, act_degree);
                return;
            end
            e = expected_q.pop_front();
            if (act_value !== e.value || act_ovf !== e.ovf || act_status !== e.status
                || act_degree !== e.degree)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp value=%h ovf=%b status=%b degree=%0d, got value=%h ovf=%b status=%b degree=%0d",
                             $realtime, e.value, e.ovf, e.status, e.degree,
                             act_value, act_ovf, act_status, act_degree);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    // exponent[5:0], value[37:6], point_a[69:38], point_b[101:70], zero pad
    logic [IN_W-1:0]    s_tdata;
    // command[2:0]
    logic [CMD_W-1:0]   s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    // result_value[31:0], overflow[32], status[33], degree[39:34]
    logic [OUT_W-1:0]   m_tdata;

    poly_scoreboard sb = new();
    int             idle_cycles = 0;
    bit             burst_mode  = 1'b0;
    bit             rx_hold_req = 1'b0;

    poly_coeff_store_integrator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[5:0], s_tdata[37:6], s_tdata[69:38],
                                s_tdata[101:70]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("[poly_coeff_store_integrator] ERROR");
        $finish;
    end

    // result side: random stall per request, one long hold-off on demand
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            stall = burst_mode ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [EXP_W-1:0] expo,
                                input q_t val, input q_t pa, input q_t pb);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, pb, pa, val, expo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic q_t rand_coeff();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
            1, 2:    return q_t'($urandom);
            default: return q_t'($urandom_range(0, 32'h0008_0000)) - q_t'(32'h0004_0000);
        endcase
    endfunction

    // mostly |x| <= 2.0 so the sums stay in range
    function automatic q_t rand_point();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
            1:       return q_t'($urandom);
            default: return q_t'($urandom_range(0, 32'h0004_0000)) - q_t'(32'h0002_0000);
        endcase
    endfunction

    task automatic send_random();
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [EXP_W-1:0]  expo;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            cmd = CMD_SET;
        else if (pick < 54)
            cmd = CMD_ADD;
        else if (pick < 58)
            cmd = CMD_CLEAR;
        else if (pick < 77)
            cmd = CMD_EVAL;
        else if (pick < 96)
            cmd = CMD_INTEG;
        else
            cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        if (cmd == CMD_SET || cmd == CMD_ADD)
            expo = ($urandom_range(0, 99) < 85) ? EXP_W'($urandom_range(0, NUM_COEFFS - 1))
                                                : EXP_W'($urandom_range(NUM_COEFFS, 63));
        else
            expo = EXP_W'($urandom_range(0, 63));
        send_request(cmd, expo, rand_coeff(), rand_point(), rand_point());
    endtask

    initial
    begin
        int n;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_SET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, ignored writes, saturation
        send_request(CMD_EVAL,  '0, '0, '0, '0);
        send_request(CMD_SET,   '0, Q_MAX, '0, '0);
        send_request(CMD_SET,   EXP_W'(NUM_COEFFS - 1), Q_MIN, '0, '0);
        send_request(CMD_SET,   EXP_W'(NUM_COEFFS), Q_ONE, '0, '0);
        send_request(CMD_ADD,   '1, Q_ONE, '1, '1);
        send_request(CMD_EVAL,  '0, '0, Q_MAX, '0);
        send_request(CMD_EVAL,  '0, '0, Q_MIN, '0);
        send_request(CMD_INTEG, '0, '0, Q_MIN, Q_MAX);
        send_request(CMD_ADD,   '0, Q_MAX, '0, '0);
        send_request(CMD_ADD,   EXP_W'(NUM_COEFFS - 1), Q_MIN, '0, '0);
        send_request(CMD_CLEAR, '1, '1, '1, '1);
        send_request(CMD_EVAL,  '1, '1, Q_ONE, '0);
        send_request(CMD_INTEG, '0, '0, Q_MIN, Q_MAX);
        send_request(CMD_SPARE_FIRST, '1, '1, '1, '1);
        send_request(CMD_SPARE_FIRST + 1'b1, '0, '0, '0, '0);
        send_request(CMD_SPARE_LAST, '1, Q_MIN, Q_MAX, Q_MIN);
        // small polynomial 1 + 2x - 3x^2
        send_request(CMD_SET,   6'd0, Q_ONE, '0, '0);
        send_request(CMD_SET,   6'd1, 2 * Q_ONE, '0, '0);
        send_request(CMD_SET,   6'd2, -3 * Q_ONE, '0, '0);
        send_request(CMD_EVAL,  '0, '0, Q_ONE, '0);
        send_request(CMD_EVAL,  '0, '0, -(Q_ONE / 2), '0);
        send_request(CMD_INTEG, '0, '0, '0, Q_ONE);
        send_request(CMD_INTEG, '0, '0, Q_ONE, Q_ONE);
        send_request(CMD_INTEG, '0, '0, 2 * Q_ONE, -Q_ONE);
        send_request(CMD_ADD,   6'd1, -2 * Q_ONE, '0, '0);
        send_request(CMD_SET,   6'd2, '0, '0, '0);

        for (n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == 150)
                rx_hold_req = 1'b1;
            if (n == 200)
                burst_mode = 1'b1;
            if (n == 260)
                burst_mode = 1'b0;
            if (n == 320)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_random();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[poly_coeff_store_integrator] OK");
        else
            $display("[poly_coeff_store_integrator] ERROR");
        $finish;
    end

endmodule
